@@ hdl/light_shadow_pixel_shader_defines.svh @@
// ----------------------------------------------------------------------------
// light shadow pixel shader assertion macros
// shared concurrent assertion forms, clocked on clk with rst as disable
// ----------------------------------------------------------------------------
`ifndef LIGHT_SHADOW_PIXEL_SHADER_DEFINES_SVH
`define LIGHT_SHADOW_PIXEL_SHADER_DEFINES_SVH

// same-cycle implication
`define LSPS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsps assertion failed");

// next-cycle implication
`define LSPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsps assertion failed");

`endif

@@ hdl/lsps_pkg.sv @@
// ----------------------------------------------------------------------------
// lsps_pkg
// types, register codes and constants of the light shadow pixel shader
// ----------------------------------------------------------------------------
package lsps_pkg;

  localparam int COORD_BITS     = 10;
  localparam int DIST_FRAC_BITS = 8;
  localparam int RADIUS_BITS    = 8;
  localparam int FALLOFF_BITS   = 11;
  localparam int LEVEL_BITS     = 8;
  localparam int COLOR_BITS     = 32;
  localparam int CFG_IDX_BITS   = 4;
  localparam int CFG_DATA_BITS  = (COORD_BITS > FALLOFF_BITS) ? COORD_BITS : FALLOFF_BITS;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_LIGHT_X      = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LIGHT_Y      = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RECT_X       = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RECT_Y       = 4'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RECT_W       = 4'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_RECT_H       = 4'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_LIGHT_RADIUS = 4'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_FALLOFF      = 4'd7;

  // register reset values
  localparam logic [COORD_BITS-1:0]   RST_LIGHT_X      = 10'd0;
  localparam logic [COORD_BITS-1:0]   RST_LIGHT_Y      = 10'd0;
  localparam logic [COORD_BITS-1:0]   RST_RECT_X       = 10'd200;
  localparam logic [COORD_BITS-1:0]   RST_RECT_Y       = 10'd200;
  localparam logic [COORD_BITS-1:0]   RST_RECT_W       = 10'd200;
  localparam logic [COORD_BITS-1:0]   RST_RECT_H       = 10'd100;
  localparam logic [RADIUS_BITS-1:0]  RST_LIGHT_RADIUS = 8'd20;
  localparam logic [FALLOFF_BITS-1:0] RST_FALLOFF      = 11'd400;

  localparam logic [COLOR_BITS-1:0] WHITE_WORD = 32'hffffffff;
  localparam logic [COLOR_BITS-1:0] BLACK_WORD = 32'h00000000;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX  = 8'hFF;

  typedef enum logic [1:0] {
    CLS_FALLOFF = 2'd0,
    CLS_SHADOW  = 2'd1,
    CLS_RECT    = 2'd2,
    CLS_DISC    = 2'd3
  } shade_class_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] pixel_color;
    logic [1:0]            shade_class;
  } shade_t;

endpackage

@@ hdl/light_shadow_pixel_shader.sv @@
// ----------------------------------------------------------------------------
// light_shadow_pixel_shader
// shades one pixel per beat for a point light and one shadow casting rectangle
// ----------------------------------------------------------------------------
// Usage:
//   pixel channel (pixel_valid / pixel_stall / pixel) takes one coordinate a
//   beat; shade channel (shade_valid / shade_stall / shade) returns its color
//   word and class in the same order. cfg channel (cfg_valid / cfg_ready,
//   cfg_index, cfg_data) writes the eight scene registers; cfg_ready is
//   always high; the user must make writes while no pixel is in flight,
//   which the block does not enforce. Throughput is one pixel per cycle
//   while the skid register is empty. From accept to shade_valid a beat
//   passes the capture stage loaded by the accepting edge, then four front
//   stages, one square root stage per root bit, one setup and eight
//   quotient stages of the level divider, and the output register.
//   The silhouette corner pair comes from the registers through three
//   registered steps, settled before the first pixel after a write needs it.
//   Reset restores the register defaults and empties the pipeline.
//   When the receiver stalls, the last result parks in a skid register and
//   the pipeline keeps moving for that cycle; it then holds, pixel_stall
//   stays high until the parked beat is taken.
// ----------------------------------------------------------------------------
`include "light_shadow_pixel_shader_defines.svh"

module light_shadow_pixel_shader #(
  parameter int DIST_FRAC_BITS = lsps_pkg::DIST_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pixel_valid,
  output logic                                 pixel_stall,
  input  lsps_pkg::pixel_t                     pixel,
  output logic                                 shade_valid,
  input  logic                                 shade_stall,
  output lsps_pkg::shade_t                     shade,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lsps_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [lsps_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int C    = lsps_pkg::COORD_BITS;
  localparam int F    = DIST_FRAC_BITS;
  localparam int RB   = lsps_pkg::RADIUS_BITS;
  localparam int FB   = lsps_pkg::FALLOFF_BITS;
  localparam int QB   = lsps_pkg::LEVEL_BITS;
  localparam int DW   = C + 1;             // pixel offset from light
  localparam int CW   = C + 2;             // corner offset from light
  localparam int PW   = CW + DW;           // ray cross partial product
  localparam int EW   = 2 * CW + 2;        // edge cross partial product
  localparam int ZW   = 2 * CW + 1;        // corner cross value
  localparam int SW   = 2 * C + 1;         // squared distance
  localparam int RW   = C + F + 1;         // root bits
  localparam int NE   = 2 * RW;            // radicand bits
  localparam int RMW  = RW + 3;            // root remainder
  localparam int DB   = FB + F;            // scaled falloff distance
  localparam int DRW  = DB + QB;           // divider remainder
  localparam int TW   = (RW > DB) ? RW : DB;
  localparam int R2W  = 2 * RB;
  localparam int F2W  = 2 * FB;
  localparam int CMPW = (SW > F2W) ? SW : F2W;
  localparam int IDX_SQ0 = 4;
  localparam int IDX_DV0 = IDX_SQ0 + RW + 1;
  localparam int NS      = IDX_DV0 + QB + 2;

  typedef struct packed {
    logic [RMW-1:0] rem;
    logic [RW-1:0]  root;
    logic [SW-1:0]  s;
    logic [1:0]     cls;
  } sq_t;

  typedef struct packed {
    logic [DRW-1:0] rem;
    logic [QB-1:0]  q;
    logic           zero;
    logic [1:0]     cls;
  } dv_t;

  // scene registers
  logic [C-1:0]  light_x, light_y, rect_x, rect_y, rect_w, rect_h;
  logic [RB-1:0] light_radius;
  logic [FB-1:0] falloff_distance;

  // register-derived values
  logic [C:0]              rect_x1, rect_y1;
  logic [R2W-1:0]          radius_sq;
  logic [F2W-1:0]          falloff_sq;
  logic [DB-1:0]           falloff_q;
  logic signed [CW-1:0]    crx [4];
  logic signed [CW-1:0]    cry [4];
  logic                    cp [4][4];
  logic                    cn [4][4];
  logic                    cp_next [4][4];
  logic                    cn_next [4][4];
  logic signed [CW-1:0]    pf_x, pf_y, ps_x, ps_y;
  logic signed [CW:0]      pe_x, pe_y;
  logic                    o12_p, o12_n;
  logic                    pair_any;
  logic [1:0]              pair_f, pair_s;

  // pipeline control
  logic [NS-1:0] vld;
  logic          en;
  logic          skid_v;
  lsps_pkg::shade_t skid_d;
  lsps_pkg::shade_t out_d;

  // front stages
  logic [C-1:0]         st0_x, st0_y;
  logic signed [DW-1:0] st1_dx, st1_dy;
  logic                 st1_in, st2_in, st3_in;
  logic [2*C-1:0]       st2_sqx, st2_sqy;
  logic signed [DW-1:0] st2_dx, st2_dy;
  logic [SW-1:0]        st3_s;
  logic signed [PW-1:0] st3_q1a, st3_q1b, st3_q2a, st3_q2b;
  logic signed [EW-1:0] st3_qea, st3_qeb;

  sq_t sqs [RW+1];
  dv_t dvs [QB+1];

  // ---------------------------------------------------------------------------
  // configuration write port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_x          <= lsps_pkg::RST_LIGHT_X;
      light_y          <= lsps_pkg::RST_LIGHT_Y;
      rect_x           <= lsps_pkg::RST_RECT_X;
      rect_y           <= lsps_pkg::RST_RECT_Y;
      rect_w           <= lsps_pkg::RST_RECT_W;
      rect_h           <= lsps_pkg::RST_RECT_H;
      light_radius     <= lsps_pkg::RST_LIGHT_RADIUS;
      falloff_distance <= lsps_pkg::RST_FALLOFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lsps_pkg::REG_LIGHT_X:      light_x          <= cfg_data[C-1:0];
        lsps_pkg::REG_LIGHT_Y:      light_y          <= cfg_data[C-1:0];
        lsps_pkg::REG_RECT_X:       rect_x           <= cfg_data[C-1:0];
        lsps_pkg::REG_RECT_Y:       rect_y           <= cfg_data[C-1:0];
        lsps_pkg::REG_RECT_W:       rect_w           <= cfg_data[C-1:0];
        lsps_pkg::REG_RECT_H:       rect_h           <= cfg_data[C-1:0];
        lsps_pkg::REG_LIGHT_RADIUS: light_radius     <= cfg_data[RB-1:0];
        lsps_pkg::REG_FALLOFF:      falloff_distance <= cfg_data[FB-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // scene values and corner offsets, refreshed every cycle
  always_ff @(posedge clk) begin
    rect_x1    <= (C+1)'(rect_x) + (C+1)'(rect_w);
    rect_y1    <= (C+1)'(rect_y) + (C+1)'(rect_h);
    radius_sq  <= R2W'(light_radius) * R2W'(light_radius);
    falloff_sq <= F2W'(falloff_distance) * F2W'(falloff_distance);
    falloff_q  <= {falloff_distance, F'(0)};
    crx[0] <= $signed(CW'(rect_x)) - $signed(CW'(light_x));
    cry[0] <= $signed(CW'(rect_y)) - $signed(CW'(light_y));
    crx[1] <= $signed(CW'(rect_x)) - $signed(CW'(light_x));
    cry[1] <= $signed(CW'(rect_y) + CW'(rect_h)) - $signed(CW'(light_y));
    crx[2] <= $signed(CW'(rect_x) + CW'(rect_w)) - $signed(CW'(light_x));
    cry[2] <= $signed(CW'(rect_y)) - $signed(CW'(light_y));
    crx[3] <= $signed(CW'(rect_x) + CW'(rect_w)) - $signed(CW'(light_x));
    cry[3] <= $signed(CW'(rect_y) + CW'(rect_h)) - $signed(CW'(light_y));
  end

  // cross product signs between corner rays, one lane per corner pair
  always_comb begin
    logic signed [2*CW-1:0] pa, pb;
    logic signed [ZW-1:0]   z;
    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 4; b++) begin
        cp_next[a][b] = 1'b0;
        cn_next[a][b] = 1'b0;
      end
    end
    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 4; b++) begin
        if (a < b) begin
          pa = crx[a] * cry[b];
          pb = crx[b] * cry[a];
          z  = ZW'(pa) - ZW'(pb);
          cp_next[a][b] = !z[ZW-1] && (z != '0);
          cn_next[a][b] = z[ZW-1];
          cp_next[b][a] = z[ZW-1];
          cn_next[b][a] = !z[ZW-1] && (z != '0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cp <= cp_next;
    cn <= cn_next;
  end

  // silhouette pair: first passing partner per corner, last corner wins
  always_comb begin
    logic found;
    logic ok;
    pair_any = 1'b0;
    pair_f   = 2'd0;
    pair_s   = 2'd0;
    for (int i = 0; i < 4; i++) begin
      found = 1'b0;
      for (int j = 0; j < 4; j++) begin
        if (j > i && !found) begin
          ok = 1'b1;
          for (int k = 0; k < 4; k++) begin
            if (k != i && k != j) begin
              if (cp[i][j] && (!cp[i][k] || !cn[j][k])) ok = 1'b0;
              if (cn[i][j] && (!cn[i][k] || !cp[j][k])) ok = 1'b0;
            end
          end
          if (ok) begin
            found    = 1'b1;
            pair_any = 1'b1;
            pair_f   = 2'(i);
            pair_s   = 2'(j);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pair_any) begin
      pf_x  <= crx[pair_f];
      pf_y  <= cry[pair_f];
      ps_x  <= crx[pair_s];
      ps_y  <= cry[pair_s];
      pe_x  <= (CW+1)'(crx[pair_s]) - (CW+1)'(crx[pair_f]);
      pe_y  <= (CW+1)'(cry[pair_s]) - (CW+1)'(cry[pair_f]);
      o12_p <= cp[pair_f][pair_s];
      o12_n <= cn[pair_f][pair_s];
    end else begin
      pf_x  <= '0;
      pf_y  <= '0;
      ps_x  <= '0;
      ps_y  <= '0;
      pe_x  <= '0;
      pe_y  <= '0;
      o12_p <= 1'b0;
      o12_n <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline advance and valid bits
  assign en          = !skid_v;
  assign pixel_stall = skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], pixel_valid};
    end
  end

  // stage 0: capture beat
  always_ff @(posedge clk) begin
    if (en) begin
      st0_x <= pixel.pixel_x;
      st0_y <= pixel.pixel_y;
    end
  end

  // stage 1: offsets from the light, rectangle test
  always_ff @(posedge clk) begin
    if (en) begin
      st1_dx <= $signed(DW'(st0_x)) - $signed(DW'(light_x));
      st1_dy <= $signed(DW'(st0_y)) - $signed(DW'(light_y));
      st1_in <= (DW'(st0_x) >= DW'(rect_x)) && (DW'(st0_x) <= rect_x1) &&
                (DW'(st0_y) >= DW'(rect_y)) && (DW'(st0_y) <= rect_y1);
    end
  end

  // stage 2: squares
  logic signed [2*DW-1:0] mul_xx, mul_yy;
  assign mul_xx = st1_dx * st1_dx;
  assign mul_yy = st1_dy * st1_dy;

  always_ff @(posedge clk) begin
    if (en) begin
      st2_sqx <= mul_xx[2*C-1:0];
      st2_sqy <= mul_yy[2*C-1:0];
      st2_dx  <= st1_dx;
      st2_dy  <= st1_dy;
      st2_in  <= st1_in;
    end
  end

  // stage 3: distance sum and shadow ray partial products
  logic signed [CW:0]   rel_x, rel_y;
  logic signed [PW-1:0] q1a, q1b, q2a, q2b;
  logic signed [EW-1:0] qea, qeb;
  assign rel_x = (CW+1)'(st2_dx) - (CW+1)'(pf_x);
  assign rel_y = (CW+1)'(st2_dy) - (CW+1)'(pf_y);
  assign q1a   = pf_x * st2_dy;
  assign q1b   = st2_dx * pf_y;
  assign q2a   = ps_x * st2_dy;
  assign q2b   = st2_dx * ps_y;
  assign qea   = pe_x * rel_y;
  assign qeb   = pe_y * rel_x;

  always_ff @(posedge clk) begin
    if (en) begin
      st3_s   <= SW'(st2_sqx) + SW'(st2_sqy);
      st3_q1a <= q1a;
      st3_q1b <= q1b;
      st3_q2a <= q2a;
      st3_q2b <= q2b;
      st3_qea <= qea;
      st3_qeb <= qeb;
      st3_in  <= st2_in;
    end
  end

  // stage 4: classify
  logic signed [PW:0] z1, z2;
  logic signed [EW:0] ze;
  logic               p1, n1, p2, n2, pe, ne, shadow;
  logic [1:0]         cls_c;

  always_comb begin
    z1 = (PW+1)'(st3_q1a) - (PW+1)'(st3_q1b);
    z2 = (PW+1)'(st3_q2a) - (PW+1)'(st3_q2b);
    ze = (EW+1)'(st3_qea) - (EW+1)'(st3_qeb);
    p1 = !z1[PW] && (z1 != '0);
    n1 = z1[PW];
    p2 = !z2[PW] && (z2 != '0);
    n2 = z2[PW];
    pe = !ze[EW] && (ze != '0);
    ne = ze[EW];
    shadow = ((p1 && n2) || (n1 && p2)) && (o12_p == ne) && (o12_n == pe);
    if (CMPW'(st3_s) < CMPW'(radius_sq)) begin
      cls_c = lsps_pkg::CLS_DISC;
    end else if (st3_in && (CMPW'(st3_s) <= CMPW'(falloff_sq))) begin
      cls_c = lsps_pkg::CLS_RECT;
    end else if (shadow) begin
      cls_c = lsps_pkg::CLS_SHADOW;
    end else begin
      cls_c = lsps_pkg::CLS_FALLOFF;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqs[0].rem  <= '0;
      sqs[0].root <= '0;
      sqs[0].s    <= st3_s;
      sqs[0].cls  <= cls_c;
    end
  end

  // square root of s scaled by the fraction bits, one root bit per stage
  for (genvar g = 0; g < RW; g++) begin : g_sqrt
    logic [NE-1:0]  rad;
    logic [RMW-1:0] cur, trial;
    sq_t            nxt;
    always_comb begin
      rad   = NE'(sqs[g].s) << (2 * F);
      cur   = {sqs[g].rem[RMW-3:0], rad[NE-1-2*g -: 2]};
      trial = RMW'({sqs[g].root, 2'b01});
      nxt   = sqs[g];
      if (cur >= trial) begin
        nxt.rem  = cur - trial;
        nxt.root = {sqs[g].root[RW-2:0], 1'b1};
      end else begin
        nxt.rem  = cur;
        nxt.root = {sqs[g].root[RW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (en) sqs[g+1] <= nxt;
    end
  end

  // level divider setup: numerator 255 * (Dq - d)
  logic          lvl_lt;
  logic [DB-1:0] lvl_diff;
  assign lvl_lt   = TW'(sqs[RW].root) < TW'(falloff_q);
  assign lvl_diff = falloff_q - DB'(sqs[RW].root);

  always_ff @(posedge clk) begin
    if (en) begin
      dvs[0].rem  <= lvl_lt ? DRW'(lvl_diff) * DRW'(lsps_pkg::LEVEL_MAX) : '0;
      dvs[0].q    <= '0;
      dvs[0].zero <= !lvl_lt;
      dvs[0].cls  <= sqs[RW].cls;
    end
  end

  // restoring division by Dq, one quotient bit per stage
  for (genvar g = 1; g <= QB; g++) begin : g_div
    logic [DRW-1:0] dsh;
    dv_t            nxt;
    always_comb begin
      dsh = DRW'(falloff_q) << (QB - g);
      nxt = dvs[g-1];
      if (dvs[g-1].rem >= dsh) begin
        nxt.rem = dvs[g-1].rem - dsh;
        nxt.q   = dvs[g-1].q | (QB'(1) << (QB - g));
      end
    end
    always_ff @(posedge clk) begin
      if (en) dvs[g] <= nxt;
    end
  end

  // output register: color word by class
  logic [QB-1:0] level;
  assign level = dvs[QB].zero ? '0 : dvs[QB].q;

  always_ff @(posedge clk) begin
    if (en) begin
      out_d.shade_class <= dvs[QB].cls;
      case (dvs[QB].cls)
        lsps_pkg::CLS_DISC,
        lsps_pkg::CLS_RECT:   out_d.pixel_color <= lsps_pkg::WHITE_WORD;
        lsps_pkg::CLS_SHADOW: out_d.pixel_color <= lsps_pkg::BLACK_WORD;
        default:              out_d.pixel_color <= {level, level, level, QB'(0)};
      endcase
    end
  end

  // skid register parks the last beat while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (!shade_stall) skid_v <= 1'b0;
    end else if (vld[NS-1] && shade_stall) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v) skid_d <= out_d;
  end

  assign shade_valid = skid_v || vld[NS-1];
  assign shade       = skid_v ? skid_d : out_d;

  // ---------------------------------------------------------------------------
  // assertions
  `LSPS_ASSERT_IMPLY(a_shadow_black,
    shade_valid && (shade.shade_class == lsps_pkg::CLS_SHADOW),
    shade.pixel_color == lsps_pkg::BLACK_WORD)
  `LSPS_ASSERT_IMPLY(a_falloff_low_byte,
    shade_valid && (shade.shade_class == lsps_pkg::CLS_FALLOFF),
    shade.pixel_color[7:0] == 8'h00)
  `LSPS_ASSERT_NEXT(a_skid_capture,
    vld[NS-1] && shade_stall && !skid_v, skid_v)
  `LSPS_ASSERT_NEXT(a_skid_hold,
    skid_v && shade_stall, skid_v && $stable(skid_d))

endmodule

@@ verif/light_shadow_pixel_shader_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// light shadow pixel shader testbench
// drives pixel beats through several scene settings with random idle and
// stall patterns and checks every shaded beat against an in-bench predictor
// ----------------------------------------------------------------------------
module light_shadow_pixel_shader_test;

  localparam int LATENCY_WAIT = 48;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_CYCLES  = 300;

  logic                                 clk;
  logic                                 rst;
  logic                                 pixel_valid;
  logic                                 pixel_stall;
  lsps_pkg::pixel_t                     pixel;
  logic                                 shade_valid;
  logic                                 shade_stall;
  lsps_pkg::shade_t                     shade;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic [lsps_pkg::CFG_IDX_BITS-1:0]    cfg_index;
  logic [lsps_pkg::CFG_DATA_BITS-1:0]   cfg_data;

  light_shadow_pixel_shader uut (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
    .shade_valid(shade_valid), .shade_stall(shade_stall), .shade(shade),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // scene registers as the block should hold them
  logic [lsps_pkg::COORD_BITS-1:0]   sc_lx, sc_ly, sc_rx, sc_ry, sc_rw, sc_rh;
  logic [lsps_pkg::RADIUS_BITS-1:0]  sc_radius;
  logic [lsps_pkg::FALLOFF_BITS-1:0] sc_falloff;

  lsps_pkg::pixel_t pending_pixels[$];
  lsps_pkg::shade_t expected_shades[$];
  int     send_idle_pct;
  int     recv_stall_pct;
  int     hold_requests = 0;
  int     hold_served = 0;
  int     hold_left = 0;
  int     errors = 0;
  int     beats_checked = 0;
  int     cycles = 0;
  int     class_seen[4];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int cross_sign(longint ax, longint ay, longint bx, longint by);
    longint z;
    z = ax * by - bx * ay;
    return (z > 0) ? 1 : ((z < 0) ? -1 : 0);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // color and class of one pixel under the current scene
  function automatic lsps_pkg::shade_t shade_pixel(lsps_pkg::pixel_t p);
    longint px, py, lx, ly, x0, y0, x1, y1, dx, dy, fx, fy, sx, sy;
    longint cx[4], cy[4];
    longint unsigned s, d_lim, rad, dq, dq_lim, lvl;
    int o, ol, orr, o1, o2, o12, oe;
    bit ok;
    lsps_pkg::shade_t r;
    px = p.pixel_x; py = p.pixel_y;
    lx = sc_lx; ly = sc_ly;
    x0 = sc_rx; y0 = sc_ry;
    x1 = x0 + sc_rw; y1 = y0 + sc_rh;
    dx = px - lx; dy = py - ly;
    s = dx * dx + dy * dy;
    d_lim = sc_falloff; rad = sc_radius;
    fx = 0; fy = 0; sx = 0; sy = 0;
    cx[0] = x0 - lx; cy[0] = y0 - ly;
    cx[1] = x0 - lx; cy[1] = y1 - ly;
    cx[2] = x1 - lx; cy[2] = y0 - ly;
    cx[3] = x1 - lx; cy[3] = y1 - ly;
    // silhouette corner pair, last found wins
    for (int i = 0; i < 4; i++) begin
      for (int j = i + 1; j < 4; j++) begin
        o = cross_sign(cx[i], cy[i], cx[j], cy[j]);
        ok = 1'b1;
        for (int k = 0; k < 4; k++) begin
          if (ok && k != i && k != j) begin
            ol = cross_sign(cx[i], cy[i], cx[k], cy[k]);
            orr = cross_sign(cx[j], cy[j], cx[k], cy[k]);
            if (o == 1 && (ol != 1 || orr != -1)) ok = 1'b0;
            if (o == -1 && (ol != -1 || orr != 1)) ok = 1'b0;
          end
        end
        if (ok) begin
          fx = cx[i]; fy = cy[i]; sx = cx[j]; sy = cy[j];
          break;
        end
      end
    end
    if (s < rad * rad) begin
      r.pixel_color = lsps_pkg::WHITE_WORD;
      r.shade_class = lsps_pkg::CLS_DISC;
    end else if (px >= x0 && px <= x1 && py >= y0 && py <= y1 && s <= d_lim * d_lim) begin
      r.pixel_color = lsps_pkg::WHITE_WORD;
      r.shade_class = lsps_pkg::CLS_RECT;
    end else begin
      o1 = cross_sign(fx, fy, dx, dy);
      o2 = cross_sign(sx, sy, dx, dy);
      o12 = cross_sign(fx, fy, sx, sy);
      oe = cross_sign(sx - fx, sy - fy, dx - fx, dy - fy);
      if (((o1 == 1 && o2 == -1) || (o1 == -1 && o2 == 1)) && o12 == -oe) begin
        r.pixel_color = lsps_pkg::BLACK_WORD;
        r.shade_class = lsps_pkg::CLS_SHADOW;
      end else begin
        dq = int_sqrt(s << (2 * lsps_pkg::DIST_FRAC_BITS));
        dq_lim = d_lim << lsps_pkg::DIST_FRAC_BITS;
        lvl = 0;
        if (dq_lim != 0 && dq < dq_lim) lvl = (255 * (dq_lim - dq)) / dq_lim;
        lvl = lvl & 8'hff;
        r.pixel_color = {lvl[7:0], lvl[7:0], lvl[7:0], 8'h00};
        r.shade_class = lsps_pkg::CLS_FALLOFF;
      end
    end
    return r;
  endfunction

  // pixel driver, predicts each accepted beat
  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
      pixel <= '0;
    end else begin
      if (pixel_valid && !pixel_stall) begin
        expected_shades.insert(expected_shades.size(), shade_pixel(pixel));
      end
      if (!pixel_valid || !pixel_stall) begin
        if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          pixel <= pending_pixels.pop_front();
          pixel_valid <= 1'b1;
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with a long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      shade_stall <= 1'b0;
    end else if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES - 1;
      shade_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      shade_stall <= 1'b1;
    end else begin
      shade_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // shade monitor
  always @(posedge clk) begin
    lsps_pkg::shade_t want;
    if (!rst && shade_valid && !shade_stall) begin
      if (expected_shades.size() == 0) begin
        errors++;
        $display("%0t: unexpected shade beat color %h class %0d",
                 $time, shade.pixel_color, shade.shade_class);
      end else begin
        want = expected_shades.pop_front();
        beats_checked++;
        class_seen[want.shade_class]++;
        if (shade.pixel_color !== want.pixel_color) begin
          errors++;
          $display("%0t: pixel_color expected %h actual %h",
                   $time, want.pixel_color, shade.pixel_color);
        end
        if (shade.shade_class !== want.shade_class) begin
          errors++;
          $display("%0t: shade_class expected %0d actual %0d",
                   $time, want.shade_class, shade.shade_class);
        end
      end
    end
  end

  // scene register shadow, follows accepted writes
  always @(posedge clk) begin
    if (rst) begin
      sc_lx <= lsps_pkg::RST_LIGHT_X; sc_ly <= lsps_pkg::RST_LIGHT_Y;
      sc_rx <= lsps_pkg::RST_RECT_X;  sc_ry <= lsps_pkg::RST_RECT_Y;
      sc_rw <= lsps_pkg::RST_RECT_W;  sc_rh <= lsps_pkg::RST_RECT_H;
      sc_radius <= lsps_pkg::RST_LIGHT_RADIUS; sc_falloff <= lsps_pkg::RST_FALLOFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lsps_pkg::REG_LIGHT_X:      sc_lx <= cfg_data[lsps_pkg::COORD_BITS-1:0];
        lsps_pkg::REG_LIGHT_Y:      sc_ly <= cfg_data[lsps_pkg::COORD_BITS-1:0];
        lsps_pkg::REG_RECT_X:       sc_rx <= cfg_data[lsps_pkg::COORD_BITS-1:0];
        lsps_pkg::REG_RECT_Y:       sc_ry <= cfg_data[lsps_pkg::COORD_BITS-1:0];
        lsps_pkg::REG_RECT_W:       sc_rw <= cfg_data[lsps_pkg::COORD_BITS-1:0];
        lsps_pkg::REG_RECT_H:       sc_rh <= cfg_data[lsps_pkg::COORD_BITS-1:0];
        lsps_pkg::REG_LIGHT_RADIUS: sc_radius <= cfg_data[lsps_pkg::RADIUS_BITS-1:0];
        lsps_pkg::REG_FALLOFF:      sc_falloff <= cfg_data[lsps_pkg::FALLOFF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic cfg_write(logic [lsps_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [lsps_pkg::CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_scene(int lx, int ly, int rx, int ry, int rw, int rh, int rad, int fall);
    cfg_write(lsps_pkg::REG_LIGHT_X, lsps_pkg::CFG_DATA_BITS'(lx));
    cfg_write(lsps_pkg::REG_LIGHT_Y, lsps_pkg::CFG_DATA_BITS'(ly));
    cfg_write(lsps_pkg::REG_RECT_X, lsps_pkg::CFG_DATA_BITS'(rx));
    cfg_write(lsps_pkg::REG_RECT_Y, lsps_pkg::CFG_DATA_BITS'(ry));
    cfg_write(lsps_pkg::REG_RECT_W, lsps_pkg::CFG_DATA_BITS'(rw));
    cfg_write(lsps_pkg::REG_RECT_H, lsps_pkg::CFG_DATA_BITS'(rh));
    cfg_write(lsps_pkg::REG_LIGHT_RADIUS, lsps_pkg::CFG_DATA_BITS'(rad));
    cfg_write(lsps_pkg::REG_FALLOFF, lsps_pkg::CFG_DATA_BITS'(fall));
    // let the corner pair settle
    repeat (8) @(posedge clk);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_pixels.size() != 0 || expected_shades.size() != 0 || pixel_valid);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic add_pixel(int x, int y);
    lsps_pkg::pixel_t p;
    p.pixel_x = lsps_pkg::COORD_BITS'(x);
    p.pixel_y = lsps_pkg::COORD_BITS'(y);
    pending_pixels.insert(pending_pixels.size(), p);
  endtask

  // mostly pixels near the light and rectangle corners, some uniform
  task automatic add_random_pixels(int n);
    int bx, by, pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(9);
      if (pick < 6) begin
        case ($urandom_range(2))
          0: begin bx = sc_lx; by = sc_ly; end
          1: begin bx = sc_rx; by = sc_ry; end
          default: begin bx = sc_rx + sc_rw; by = sc_ry + sc_rh; end
        endcase
        add_pixel((bx + $urandom_range(255) - 128) & 10'h3ff,
                  (by + $urandom_range(255) - 128) & 10'h3ff);
      end else begin
        add_pixel($urandom_range(1023), $urandom_range(1023));
      end
    end
  endtask

  task automatic set_idling(int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
      default: begin send_idle_pct = 33; recv_stall_pct = 33; end
    endcase
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    repeat (8) @(posedge clk);

    // directed pixels under the reset scene
    add_pixel(0, 0);       add_pixel(1023, 1023); add_pixel(0, 1023);
    add_pixel(1023, 0);    add_pixel(19, 0);      add_pixel(20, 0);
    add_pixel(12, 16);     add_pixel(200, 200);   add_pixel(400, 300);
    add_pixel(200, 300);   add_pixel(400, 200);   add_pixel(300, 250);
    add_pixel(500, 400);   add_pixel(600, 300);   add_pixel(450, 250);
    add_pixel(600, 600);   add_pixel(283, 283);   add_pixel(399, 0);
    add_pixel(0, 400);     add_pixel(682, 341);   add_pixel(700, 710);
    add_random_pixels(80);
    wait_drained();

    for (int phase = 1; phase < 12; phase++) begin
      case (phase)
        // degenerate point rectangle at the origin, zero radius
        1: load_scene(0, 0, 0, 0, 0, 0, 0, 1);
        // everything at its top value, rectangle past the grid
        2: load_scene(1023, 1023, 1023, 1023, 1023, 1023, 255, 2047);
        // light inside the rectangle
        3: load_scene(500, 500, 300, 300, 400, 400, 30, 800);
        // light in line with the left edge, zero falloff distance
        4: load_scene(100, 300, 100, 500, 200, 100, 10, 0);
        5: load_scene(700, 100, 200, 200, 200, 100, 0, 1500);
        default: begin
          load_scene($urandom_range(2047), $urandom_range(2047), $urandom_range(2047),
                     $urandom_range(2047), $urandom_range(2047), $urandom_range(2047),
                     $urandom_range(2047), $urandom_range(2047));
          cfg_write(lsps_pkg::CFG_IDX_BITS'($urandom_range(15, 8)),
                    lsps_pkg::CFG_DATA_BITS'($urandom_range(2047)));
        end
      endcase
      set_idling(phase);
      if (phase == 5) begin
        // long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        hold_requests++;
      end
      add_random_pixels(100);
      wait_drained();
    end

    $display("covered %0d shaded beats over 12 scenes: %0d falloff, %0d shadow,",
             beats_checked, class_seen[0], class_seen[1]);
    $display("%0d lit rectangle, %0d light disc, under idle, stall and hold-off phases",
             class_seen[2], class_seen[3]);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
